// File: rtl/udlf_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// udlf_pkg
// Shared types and constants for the UTF-8 decoder with letter fold.
// ---------------------------------------------------------------------------
package udlf_pkg;

   localparam int unsigned CODE_W  = 21;
   localparam int unsigned CHAR_W  = 11;

   localparam logic [CODE_W-1:0] MIN_LEN2     = 21'h00080;
   localparam logic [CODE_W-1:0] MIN_LEN3     = 21'h00800;
   localparam logic [CODE_W-1:0] MIN_LEN4     = 21'h10000;
   localparam logic [CODE_W-1:0] MAX_CODE     = 21'h10FFFF;
   localparam logic [CODE_W-1:0] SURR_LO      = 21'h0D800;
   localparam logic [CODE_W-1:0] SURR_HI      = 21'h0DFFF;
   localparam logic [CODE_W-1:0] CYR_UP_LO    = 21'h00410;
   localparam logic [CODE_W-1:0] CYR_UP_HI    = 21'h0042F;
   localparam logic [CODE_W-1:0] CYR_IO_UP    = 21'h00401;
   localparam logic [CODE_W-1:0] CYR_IO_LO    = 21'h00451;
   localparam logic [CODE_W-1:0] CYR_LO_LO    = 21'h00430;
   localparam logic [CODE_W-1:0] CYR_LO_HI    = 21'h0044F;
   localparam logic [CODE_W-1:0] FOLD_OFFSET  = 21'h00020;

   localparam logic [2:0] LEN_NONE = 3'd0;
   localparam logic [2:0] LEN_2    = 3'd2;
   localparam logic [2:0] LEN_3    = 3'd3;
   localparam logic [2:0] LEN_4    = 3'd4;

   // open sequence state carried between words
   typedef struct packed {
      logic [CODE_W-1:0] partial_code;
      logic [1:0]        bytes_remaining;
      logic [2:0]        sequence_length;
   } seq_state_type;

   // one result word
   typedef struct packed {
      logic              char_kept;
      logic [CHAR_W-1:0] folded_char;
      logic              text_done;
   } result_type;

endpackage

`default_nettype wire

// File: rtl/udlf_decode.sv
`default_nettype none
// ---------------------------------------------------------------------------
// udlf_decode
// One-byte step of the UTF-8 decoder: sequence tracking, validation and fold.
// ---------------------------------------------------------------------------
module udlf_decode (
   input  wire logic [7:0]             text_byte,
   input  wire logic                   end_of_text,
   input  wire udlf_pkg::seq_state_type state_cur,
   output udlf_pkg::seq_state_type     state_nxt,
   output udlf_pkg::result_type        result
);

   logic                          is_cont;
   logic [udlf_pkg::CODE_W-1:0]   shifted;
   logic [1:0]                    remain_dec;
   logic [udlf_pkg::CODE_W-1:0]   minimum;
   logic                          have;
   logic [udlf_pkg::CODE_W-1:0]   code;
   logic [udlf_pkg::CODE_W-1:0]   low;
   logic                          ident;

   assign is_cont    = (text_byte[7:6] == 2'b10);
   assign shifted    = {state_cur.partial_code[udlf_pkg::CODE_W-7:0], text_byte[5:0]};
   assign remain_dec = state_cur.bytes_remaining - 2'd1;

   always_comb begin
      case (state_cur.sequence_length)
         udlf_pkg::LEN_2: minimum = udlf_pkg::MIN_LEN2;
         udlf_pkg::LEN_3: minimum = udlf_pkg::MIN_LEN3;
         default:         minimum = udlf_pkg::MIN_LEN4;
      endcase
   end

   always_comb begin
      have      = 1'b0;
      code      = '0;
      state_nxt = '0;
      if ((state_cur.bytes_remaining != 2'd0) && is_cont) begin
         if (remain_dec == 2'd0) begin
            // sequence complete: reject overlong, surrogate and out of range
            if ((shifted >= minimum) && (shifted <= udlf_pkg::MAX_CODE) &&
                !((shifted >= udlf_pkg::SURR_LO) && (shifted <= udlf_pkg::SURR_HI))) begin
               have = 1'b1;
               code = shifted;
            end
         end else begin
            state_nxt.partial_code    = shifted;
            state_nxt.bytes_remaining = remain_dec;
            state_nxt.sequence_length = state_cur.sequence_length;
         end
      end else begin
         // new lead; any open sequence is abandoned
         if (text_byte[7] == 1'b0) begin
            have = 1'b1;
            code = {13'd0, text_byte};
         end else if (text_byte[7:5] == 3'b110) begin
            state_nxt.partial_code    = {16'd0, text_byte[4:0]};
            state_nxt.bytes_remaining = 2'd1;
            state_nxt.sequence_length = udlf_pkg::LEN_2;
         end else if (text_byte[7:4] == 4'b1110) begin
            state_nxt.partial_code    = {17'd0, text_byte[3:0]};
            state_nxt.bytes_remaining = 2'd2;
            state_nxt.sequence_length = udlf_pkg::LEN_3;
         end else if (text_byte[7:3] == 5'b11110) begin
            state_nxt.partial_code    = {18'd0, text_byte[2:0]};
            state_nxt.bytes_remaining = 2'd3;
            state_nxt.sequence_length = udlf_pkg::LEN_4;
         end
      end
      if (end_of_text) begin
         state_nxt = '0;
      end
   end

   // lower-case fold
   always_comb begin
      if ((code inside {[21'h41 : 21'h5A]}) ||
          (code inside {[udlf_pkg::CYR_UP_LO : udlf_pkg::CYR_UP_HI]})) begin
         low = code + udlf_pkg::FOLD_OFFSET;
      end else if (code == udlf_pkg::CYR_IO_UP) begin
         low = udlf_pkg::CYR_IO_LO;
      end else begin
         low = code;
      end
   end

   assign ident = (low inside {[21'h30 : 21'h39]}) ||
                  (low inside {[21'h61 : 21'h7A]}) ||
                  (low inside {[udlf_pkg::CYR_LO_LO : udlf_pkg::CYR_LO_HI]}) ||
                  (low == udlf_pkg::CYR_IO_LO);

   always_comb begin
      result.char_kept   = have && ident;
      result.folded_char = (have && ident) ? low[udlf_pkg::CHAR_W-1:0] : '0;
      result.text_done   = end_of_text;
   end

endmodule

`default_nettype wire

// File: rtl/utf8_decode_letter_fold.sv
`default_nettype none
// An accepted byte's result word reaches rsp_ from the output register, via the skid entry if stalled.
// Throughput: one byte per cycle while req_stall is low; the decode step is a single combinational
//   pass from the sequence state register, so bytes can follow back to back.
// A two-entry output (result register plus skid) keeps req_stall registered.
// Reset (synchronous, active high) closes any open sequence and empties the
//   output stage.
// ---------------------------------------------------------------------------
// utf8_decode_letter_fold
// Streaming UTF-8 decoder with validation and Latin/Cyrillic lower-case fold.
// ---------------------------------------------------------------------------
module utf8_decode_letter_fold (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_stall,
   input  wire logic [7:0]  req_text_byte,
   input  wire logic        req_end_of_text,
   output      logic        rsp_valid,
   input  wire logic        rsp_stall,
   output      logic        rsp_char_kept,
   output      logic [10:0] rsp_folded_char,
   output      logic        rsp_text_done
);

   // sequence state: partial code point, continuation count, sequence length
   udlf_pkg::seq_state_type state_ff;
   udlf_pkg::seq_state_type state_in;

   // result of the word being accepted this cycle
   udlf_pkg::result_type    result_in;

   // output register and skid entry
   udlf_pkg::result_type    out_ff;
   logic                    out_valid_ff;
   udlf_pkg::result_type    skid_ff;
   logic                    skid_valid_ff;

   logic                    accept;
   logic                    out_load;

   udlf_decode u_decode (
      .text_byte   (req_text_byte),
      .end_of_text (req_end_of_text),
      .state_cur   (state_ff),
      .state_nxt   (state_in),
      .result      (result_in)
   );

   // stall only once the skid entry holds a word; registered, no path from rsp_stall
   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !skid_valid_ff;
   // output register may take a new word when empty or draining this cycle
   assign out_load  = !out_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (accept) begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_load) begin
         if (skid_valid_ff) begin
            // skid drains first; no word accepted while it is full
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff  <= accept;
         end
      end else if (accept) begin
         skid_valid_ff <= 1'b1;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (out_load) begin
         out_ff <= skid_valid_ff ? skid_ff : result_in;
      end
      if (!out_load && accept) begin
         skid_ff <= result_in;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_char_kept   = out_ff.char_kept;
   assign rsp_folded_char = out_ff.folded_char;
   assign rsp_text_done   = out_ff.text_done;

   // -------------------------------------------------------------------------
   // assertions
   // -------------------------------------------------------------------------

   // an open sequence always has its length recorded, and a closed one none
   a_state_consistent: assert property (@(posedge clock) disable iff (reset)
      (state_ff.bytes_remaining == 2'd0) == (state_ff.sequence_length == udlf_pkg::LEN_NONE))
      else $error("sequence count and length disagree");

   // end of text leaves no sequence open
   a_eot_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && req_end_of_text) |=> (state_ff == '0))
      else $error("sequence state not cleared after end of text");

   // skid only fills behind a stalled output word
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry valid with empty output register");

   // a dropped word carries a zero character
   a_drop_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_char_kept) |-> (rsp_folded_char == 11'd0))
      else $error("non-zero character on a dropped word");

   // a kept character lies in one of the passed ranges
   a_kept_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_char_kept) |->
         ((rsp_folded_char >= 11'h030 && rsp_folded_char <= 11'h039) ||
          (rsp_folded_char >= 11'h061 && rsp_folded_char <= 11'h07A) ||
          (rsp_folded_char >= 11'h430 && rsp_folded_char <= 11'h44F) ||
          (rsp_folded_char == 11'h451)))
      else $error("kept character outside the passed set");

endmodule

`default_nettype wire

// File: verif/utf8_decode_letter_fold_test.sv
`default_nettype none
// ---------------------------------------------------------------------------
// utf8_decode_letter_fold_test
// Self-checking bench for the UTF-8 decoder with Latin/Cyrillic lower-case
// fold. Bytes are sent through the req_ channel with random gaps while rsp_
// is stalled at random. Each accepted byte runs through a local decoder and
// fold, and the expected word is queued. Each result word is checked field by
// field against the oldest queued word. A short directed part comes first.
// It covers byte extremes, folds, rejected forms and broken sequences. A long
// random part of mostly well-formed text with some noise follows.
// ---------------------------------------------------------------------------
module utf8_decode_letter_fold_test;

   typedef logic [udlf_pkg::CODE_W-1:0] code_type;

   // cycles with no word moving on either channel before the run is called dead
   localparam int unsigned IDLE_LIMIT = 2000;

   // character range bounds for the fold and the identity filter
   localparam code_type CH_DIGIT_0 = 21'h00030;
   localparam code_type CH_DIGIT_9 = 21'h00039;
   localparam code_type CH_UPPER_A = 21'h00041;
   localparam code_type CH_UPPER_Z = 21'h0005A;
   localparam code_type CH_LOWER_A = 21'h00061;
   localparam code_type CH_LOWER_Z = 21'h0007A;

   logic        clock;
   logic        reset           = 1'b1;
   logic        req_valid       = 1'b0;
   logic        req_stall;
   logic [7:0]  req_text_byte   = 8'h00;
   logic        req_end_of_text = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall       = 1'b0;
   logic        rsp_char_kept;
   logic [10:0] rsp_folded_char;
   logic        rsp_text_done;

   // local copy of the open sequence
   code_type          seq_code = '0;
   logic [1:0]        seq_left = 2'd0;
   logic [2:0]        seq_len  = udlf_pkg::LEN_NONE;

   udlf_pkg::result_type awaited_chars[$];   // folded results still owed by the block
   int unsigned mismatch_count = 0;
   int unsigned bytes_sent     = 0;
   int unsigned idle_cycles    = 0;
   int unsigned stall_left     = 0;
   bit          no_idle        = 1'b0;   // set for stretches at full rate

   utf8_decode_letter_fold i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_text_byte   (req_text_byte),
      .req_end_of_text (req_end_of_text),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_char_kept   (rsp_char_kept),
      .rsp_folded_char (rsp_folded_char),
      .rsp_text_done   (rsp_text_done)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Gap length for either side: mostly none or short, now and then long.
   function automatic int unsigned pick_gap();
      int unsigned r;
      if (no_idle) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Decode one byte, fold, filter, and queue the word the block owes for it.
   // Mirrors the sequence state: continuation bytes extend an open sequence,
   // anything else closes it and starts over as a lead byte.
   task automatic decode_and_fold(input logic [7:0] b, input logic eot);
      logic                 have;
      code_type             cp;
      code_type             low;
      code_type             floor_code;
      udlf_pkg::result_type word;
      have = 1'b0;
      cp   = '0;
      if (seq_left != 2'd0 && b[7:6] == 2'b10) begin
         seq_code = {seq_code[udlf_pkg::CODE_W-7:0], b[5:0]};
         seq_left = seq_left - 2'd1;
         if (seq_left == 2'd0) begin
            // overlong, above the top code point, or a surrogate: dropped
            floor_code = (seq_len == udlf_pkg::LEN_2) ? udlf_pkg::MIN_LEN2 :
                         (seq_len == udlf_pkg::LEN_3) ? udlf_pkg::MIN_LEN3 :
                                                        udlf_pkg::MIN_LEN4;
            if (seq_code >= floor_code && seq_code <= udlf_pkg::MAX_CODE &&
                !(seq_code >= udlf_pkg::SURR_LO && seq_code <= udlf_pkg::SURR_HI)) begin
               have = 1'b1;
               cp   = seq_code;
            end
            seq_code = '0;
            seq_len  = udlf_pkg::LEN_NONE;
         end
      end else begin
         // lead byte; an open sequence, if any, is abandoned here
         seq_left = 2'd0;
         seq_len  = udlf_pkg::LEN_NONE;
         seq_code = '0;
         if (!b[7]) begin
            have = 1'b1;
            cp   = {13'd0, b};
         end else if (b[7:5] == 3'b110) begin
            seq_code = {16'd0, b[4:0]};
            seq_left = 2'd1;
            seq_len  = udlf_pkg::LEN_2;
         end else if (b[7:4] == 4'b1110) begin
            seq_code = {17'd0, b[3:0]};
            seq_left = 2'd2;
            seq_len  = udlf_pkg::LEN_3;
         end else if (b[7:3] == 5'b11110) begin
            seq_code = {18'd0, b[2:0]};
            seq_left = 2'd3;
            seq_len  = udlf_pkg::LEN_4;
         end
         // stray continuation or 0xF8..0xFF: nothing opens
      end

      word = '0;
      if (have) begin
         low = cp;
         if (cp >= CH_UPPER_A && cp <= CH_UPPER_Z) low = cp + udlf_pkg::FOLD_OFFSET;
         else if (cp >= udlf_pkg::CYR_UP_LO && cp <= udlf_pkg::CYR_UP_HI)
            low = cp + udlf_pkg::FOLD_OFFSET;
         else if (cp == udlf_pkg::CYR_IO_UP) low = udlf_pkg::CYR_IO_LO;
         if ((low >= CH_DIGIT_0 && low <= CH_DIGIT_9) ||
             (low >= CH_LOWER_A && low <= CH_LOWER_Z) ||
             (low >= udlf_pkg::CYR_LO_LO && low <= udlf_pkg::CYR_LO_HI) ||
             low == udlf_pkg::CYR_IO_LO) begin
            word.char_kept   = 1'b1;
            word.folded_char = low[udlf_pkg::CHAR_W-1:0];
         end
      end
      word.text_done = eot;

      // end of text: byte handled first, then whatever is still open is dropped
      if (eot) begin
         seq_code = '0;
         seq_left = 2'd0;
         seq_len  = udlf_pkg::LEN_NONE;
      end
      awaited_chars = {awaited_chars, word};
   endtask

   // Present one byte, hold it until accepted, then maybe idle a while.
   // With no gap, valid stays high into the next call.
   task automatic send_word(input logic [7:0] b, input logic eot);
      int unsigned gap;
      req_valid       <= 1'b1;
      req_text_byte   <= b;
      req_end_of_text <= eot;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      decode_and_fold(b, eot);
      bytes_sent++;
      gap = pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Sender backs off until every owed word has come back.
   task automatic hold_until_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (awaited_chars.size() != 0) @(posedge clock);
   endtask

   // Encode cp in len bytes (overlong allowed) and send the first keep of them.
   task automatic send_code(input code_type cp, input int unsigned len,
                            input int unsigned keep);
      logic [7:0] seq[4];
      seq[0] = 8'h00;
      seq[1] = 8'h00;
      seq[2] = 8'h00;
      seq[3] = 8'h00;
      case (len)
         1: seq[0] = {1'b0, cp[6:0]};
         2: begin
            seq[0] = {3'b110, cp[10:6]};
            seq[1] = {2'b10, cp[5:0]};
         end
         3: begin
            seq[0] = {4'b1110, cp[15:12]};
            seq[1] = {2'b10, cp[11:6]};
            seq[2] = {2'b10, cp[5:0]};
         end
         default: begin
            seq[0] = {5'b11110, cp[20:18]};
            seq[1] = {2'b10, cp[17:12]};
            seq[2] = {2'b10, cp[11:6]};
            seq[3] = {2'b10, cp[5:0]};
         end
      endcase
      for (int unsigned i = 0; i < keep; i++)
         send_word(seq[i], $urandom_range(0, 24) == 0);
   endtask

   // ---- directed tests ----

   task automatic test_ascii_edges();
      send_word(8'h00, 1'b0);   // NUL, dropped by the filter
      send_word(8'h30, 1'b0);   // digit zero, kept
      send_word(8'h5A, 1'b0);   // Z folds to z
      send_word(8'h7F, 1'b1);   // top single byte, end of text
   endtask

   task automatic test_two_and_four_byte();
      send_word(8'hD0, 1'b0);   // Cyrillic IO capital folds to small io
      send_word(8'h81, 1'b0);
      send_word(8'hD1, 1'b0);   // last small letter, completes on end of text
      send_word(8'h8F, 1'b1);
      send_word(8'hF4, 1'b0);   // highest legal code point, not kept
      send_word(8'h8F, 1'b0);
      send_word(8'hBF, 1'b0);
      send_word(8'hBF, 1'b0);
   endtask

   task automatic test_rejected_forms();
      send_word(8'hC0, 1'b0);   // overlong two-byte
      send_word(8'h80, 1'b0);
      send_word(8'hED, 1'b0);   // surrogate
      send_word(8'hA0, 1'b0);
      send_word(8'h80, 1'b0);
      send_word(8'hF4, 1'b0);   // just above the top code point
      send_word(8'h90, 1'b0);
      send_word(8'h80, 1'b0);
      send_word(8'h80, 1'b0);
      send_word(8'hFF, 1'b0);   // bad lead
      send_word(8'h80, 1'b0);   // stray continuation
   endtask

   task automatic test_broken_sequences();
      send_word(8'hD0, 1'b0);   // open, then a plain byte takes over as lead
      send_word(8'h41, 1'b0);
      send_word(8'hD0, 1'b1);   // open sequence cut by end of text
      send_word(8'h90, 1'b0);   // now a stray continuation
   endtask

   // ---- random text ----
   // Mostly well-formed code points of every length, some noise, truncated and
   // invalid sequences; full-rate stretches and drain pauses mixed in.
   task automatic test_random_text(input int unsigned count);
      int unsigned       start;
      int unsigned       kind;
      int unsigned       len;
      int unsigned       keep;
      int unsigned       next_drain;
      int unsigned       next_mode;
      code_type          cp;
      start      = bytes_sent;
      next_drain = start + $urandom_range(100, 250);
      next_mode  = start + $urandom_range(40, 120);
      while (bytes_sent - start < count) begin
         kind = $urandom_range(0, 99);
         len  = 1;
         cp   = '0;
         if (kind < 15) cp = code_type'($urandom_range(CH_UPPER_A, CH_UPPER_Z));
         else if (kind < 25) cp = code_type'($urandom_range(CH_LOWER_A, CH_LOWER_Z));
         else if (kind < 32) cp = code_type'($urandom_range(CH_DIGIT_0, CH_DIGIT_9));
         else if (kind < 42) cp = code_type'($urandom_range(0, 'h7F));
         else if (kind < 60) begin
            cp  = code_type'($urandom_range('h400, 'h45F));
            len = 2;
         end else if (kind < 66) begin
            cp  = code_type'($urandom_range('h80, 'h7FF));
            len = 2;
         end else if (kind < 72) begin
            cp  = code_type'($urandom_range('h800, 'hFFFF));
            len = 3;
         end else if (kind < 78) begin
            cp  = code_type'($urandom_range('h10000, 'h10FFFF));
            len = 4;
         end else if (kind < 82) begin
            len = 0;   // raw byte of any value
            send_word(8'($urandom_range(0, 255)), $urandom_range(0, 24) == 0);
         end else if (kind < 85) begin
            len = 0;   // stray continuation
            send_word(8'($urandom_range('h80, 'hBF)), $urandom_range(0, 24) == 0);
         end else if (kind < 89) begin
            len = $urandom_range(2, 4);   // overlong
            cp  = code_type'((len == 2) ? $urandom_range(0, 'h7F) :
                             (len == 3) ? $urandom_range(0, 'h7FF) :
                                          $urandom_range(0, 'hFFFF));
         end else if (kind < 92) begin
            cp  = code_type'($urandom_range(udlf_pkg::SURR_LO, udlf_pkg::SURR_HI));
            len = 3;
         end else if (kind < 95) begin
            cp  = code_type'($urandom_range('h110000, 'h1FFFFF));
            len = 4;
         end else begin
            len = $urandom_range(2, 4);   // cut short below
            cp  = code_type'($urandom_range(0, 'h1FFFFF));
         end
         keep = (kind >= 95) ? $urandom_range(1, len - 1) : len;
         if (len != 0) send_code(cp, len, keep);

         if (bytes_sent >= next_mode) begin
            no_idle   = ($urandom_range(0, 3) == 0);
            next_mode = bytes_sent + $urandom_range(40, 120);
         end
         if (bytes_sent >= next_drain) begin
            hold_until_drained();
            next_drain = bytes_sent + $urandom_range(100, 250);
         end
      end
      no_idle = 1'b0;
   endtask

   // Result side stall: random gaps, none while no_idle is set.
   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else begin
         stall_left = pick_gap();
         if (stall_left != 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Each accepted result word against the oldest owed word.
   always @(posedge clock) begin : check_words
      udlf_pkg::result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited_chars.size() == 0) begin
            $display("%0t: unexpected word kept=%0d char=%h done=%0d", $time,
                     rsp_char_kept, rsp_folded_char, rsp_text_done);
            mismatch_count++;
         end else begin
            want = awaited_chars.pop_front();
            if (rsp_char_kept !== want.char_kept) begin
               $display("%0t: char_kept expected %0d actual %0d", $time,
                        want.char_kept, rsp_char_kept);
               mismatch_count++;
            end
            if (rsp_folded_char !== want.folded_char) begin
               $display("%0t: folded_char expected %h actual %h", $time,
                        want.folded_char, rsp_folded_char);
               mismatch_count++;
            end
            if (rsp_text_done !== want.text_done) begin
               $display("%0t: text_done expected %0d actual %0d", $time,
                        want.text_done, rsp_text_done);
               mismatch_count++;
            end
         end
      end
   end

   // Watchdog: nothing moving on either channel for too long ends the run.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      test_ascii_edges();
      test_two_and_four_byte();
      test_rejected_forms();
      test_broken_sequences();
      hold_until_drained();
      test_random_text(1350);

      // all bytes in; wait for the owed words, then a few more cycles for strays
      hold_until_drained();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

`default_nettype wire
